@@ hdl/flow_tuple_session_lookup_defines.svh @@
// assertion macros shared by the session lookup block
`ifndef FLOW_TUPLE_SESSION_LOOKUP_DEFINES_SVH
`define FLOW_TUPLE_SESSION_LOOKUP_DEFINES_SVH

`ifndef SYNTH
`define FTSL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
`define FTSL_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define FTSL_ASSERT(lbl, prop, msg)
`define FTSL_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

@@ hdl/ftsl_pkg.sv @@
package ftsl_pkg;

  localparam int unsigned TABLE_DEPTH_DEF = 1024;
  localparam int unsigned APB_AW          = 5;

  // opcodes in the input tuser
  localparam logic [1:0] OP_APPEND = 2'd0;
  localparam logic [1:0] OP_LOOKUP = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;

  // result status in the output tuser
  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_MISS = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  // register indexes (byte address / 4)
  localparam logic [2:0] REG_MODE     = 3'd0;
  localparam logic [2:0] REG_SIP_BASE = 3'd1;
  localparam logic [2:0] REG_DIP_BASE = 3'd2;
  localparam logic [2:0] REG_PORTS    = 3'd3;
  localparam logic [2:0] REG_SIP_CNT  = 3'd4;
  localparam logic [2:0] REG_DIP_CNT  = 3'd5;
  localparam logic [2:0] REG_SP_CNT   = 3'd6;
  localparam logic [2:0] REG_DP_CNT   = 3'd7;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_DIR_R3,
    S_DIR_SP,
    S_DIR_DP,
    S_DIR_DI,
    S_DIR_SUM,
    S_SEARCH,
    S_FINISH
  } ftsl_state_e;

  // operand pairs of the shared multiplier
  typedef enum logic [2:0] {
    MS_R2,
    MS_R3,
    MS_SP,
    MS_DP,
    MS_DI
  } ftsl_mul_e;

  typedef enum logic [1:0] {
    RS_ZERO,
    RS_COUNT,
    RS_ACC,
    RS_HIT
  } ftsl_res_e;

  typedef struct packed {
    logic        shuffled;
    logic [31:0] src_ip_base;
    logic [31:0] dst_ip_base;
    logic [31:0] port_bases;
    logic [15:0] src_ip_count;
    logic [15:0] dst_ip_count;
    logic [15:0] src_port_count;
    logic [15:0] dst_port_count;
  } ftsl_cfg_t;

  typedef struct packed {
    logic       latch;
    logic       mul_en;
    ftsl_mul_e  mul_sel;
    logic       r2_load;
    logic       acc_init;
    logic       acc_add;
    logic       append_wr;
    logic       clear;
    logic       search_start;
    logic       search_run;
    logic       res_load;
    logic [1:0] res_status;
    ftsl_res_e  res_sel;
    logic       out_load;
  } ftsl_cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       shuffled;
    logic       full;
    logic       range_ok;
    logic       hit;
    logic       search_end;
    logic       out_free;
  } ftsl_sts_t;

endpackage

@@ hdl/flow_tuple_session_lookup.sv @@
// flow tuple to session index lookup
// input stream: tuser carries the opcode (append entry, look up, clear table),
// tdata the tuple. one result transfer per input transfer: tuser status,
// tdata session index (zero unless status is ok).
// direct mode forms a mixed-radix index from the configured ranges with one
// shared 32x16 multiplier; shuffled mode walks the session table from entry 0
// at one entry per cycle, stopping at the first exact match.
// append, clear and the unused opcode go from decode straight to finish; a
// direct lookup checks the ranges, then, if all fields are in range, steps
// through the multiply and add states to the final sum; a shuffled lookup
// searches until a hit or the end of the filled table. one item is in flight
// at a time; the next input transfer is taken once the previous result sits
// in the output register, so a stalled receiver holds one result there and
// blocks only the finish of the following item.
// reset empties the table (fill count to zero) and loads the register reset
// values; no clearing pass, table words stay as they are.
// registers sit on the apb port at byte address 4*index and should be written
// only while the block is idle.
`include "flow_tuple_session_lookup_defines.svh"

module flow_tuple_session_lookup import ftsl_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = TABLE_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // src_ip[31:0], dst_ip[63:32], src_port[79:64], dst_port[95:80]
  input  logic [95:0]       s_axis_tdata,
  // opcode[1:0]
  input  logic [1:0]        s_axis_tuser,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // session_index[31:0]
  output logic [31:0]       m_axis_tdata,
  // status[1:0]
  output logic [1:0]        m_axis_tuser,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  ftsl_cfg_t cfg_q;
  ftsl_cmd_t cmd;
  ftsl_sts_t sts;
  logic      cfg_wr;
  logic [2:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.shuffled       <= 1'b0;
      cfg_q.src_ip_base    <= '0;
      cfg_q.dst_ip_base    <= '0;
      cfg_q.port_bases     <= '0;
      cfg_q.src_ip_count   <= 16'd1;
      cfg_q.dst_ip_count   <= 16'd1;
      cfg_q.src_port_count <= 16'd1;
      cfg_q.dst_port_count <= 16'd1;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_MODE:     cfg_q.shuffled       <= pwdata[0];
        REG_SIP_BASE: cfg_q.src_ip_base    <= pwdata;
        REG_DIP_BASE: cfg_q.dst_ip_base    <= pwdata;
        REG_PORTS:    cfg_q.port_bases     <= pwdata;
        REG_SIP_CNT:  cfg_q.src_ip_count   <= pwdata[15:0];
        REG_DIP_CNT:  cfg_q.dst_ip_count   <= pwdata[15:0];
        REG_SP_CNT:   cfg_q.src_port_count <= pwdata[15:0];
        REG_DP_CNT:   cfg_q.dst_port_count <= pwdata[15:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MODE:     prdata = {31'b0, cfg_q.shuffled};
      REG_SIP_BASE: prdata = cfg_q.src_ip_base;
      REG_DIP_BASE: prdata = cfg_q.dst_ip_base;
      REG_PORTS:    prdata = cfg_q.port_bases;
      REG_SIP_CNT:  prdata = {16'b0, cfg_q.src_ip_count};
      REG_DIP_CNT:  prdata = {16'b0, cfg_q.dst_ip_count};
      REG_SP_CNT:   prdata = {16'b0, cfg_q.src_port_count};
      REG_DP_CNT:   prdata = {16'b0, cfg_q.dst_port_count};
      default:      prdata = '0;
    endcase
  end

  ftsl_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ftsl_dp #(
    .TableDepth (TABLE_DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .in_data_i   (s_axis_tdata),
    .in_user_i   (s_axis_tuser),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_user_o  (m_axis_tuser)
  );

  `FTSL_ASSERT(a_busy_after_accept, (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready, "input taken while an item is in flight")
  `FTSL_ASSERT(a_out_load_free, cmd.out_load |-> sts.out_free, "result overwrites a pending transfer")
  `FTSL_ASSERT_NEVER(a_no_write_full, cmd.append_wr && sts.full, "append written into a full table")
  `FTSL_ASSERT(a_idx_zero_on_fail, (m_axis_tvalid && m_axis_tuser != ST_OK) |-> (m_axis_tdata == '0), "non-zero index with failing status")

endmodule

@@ hdl/ftsl_ram.sv @@
module ftsl_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 1024,
  localparam int unsigned Aw   = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ hdl/ftsl_ctrl.sv @@
module ftsl_ctrl import ftsl_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  ftsl_sts_t sts_i,
  output ftsl_cmd_t cmd_o
);

  ftsl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DECODE;
      end
      S_DECODE: begin
        unique case (sts_i.op)
          OP_LOOKUP: state_d = sts_i.shuffled ? S_SEARCH : S_DIR_R3;
          default:   state_d = S_FINISH;
        endcase
      end
      S_DIR_R3: begin
        state_d = sts_i.range_ok ? S_DIR_SP : S_FINISH;
      end
      S_DIR_SP:  state_d = S_DIR_DP;
      S_DIR_DP:  state_d = S_DIR_DI;
      S_DIR_DI:  state_d = S_DIR_SUM;
      S_DIR_SUM: state_d = S_FINISH;
      S_SEARCH: begin
        if (sts_i.hit || sts_i.search_end) state_d = S_FINISH;
      end
      S_FINISH: begin
        if (sts_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o            = '0;
    cmd_o.mul_sel    = MS_R2;
    cmd_o.res_sel    = RS_ZERO;
    cmd_o.res_status = ST_OK;
    in_ready_o       = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.latch = in_valid_i;
      end
      S_DECODE: begin
        unique case (sts_i.op)
          OP_APPEND: begin
            cmd_o.res_load = 1'b1;
            if (sts_i.full) begin
              cmd_o.res_status = ST_FULL;
            end else begin
              cmd_o.append_wr = 1'b1;
              cmd_o.res_sel   = RS_COUNT;
            end
          end
          OP_LOOKUP: begin
            if (sts_i.shuffled) begin
              cmd_o.search_start = 1'b1;
            end else begin
              cmd_o.mul_en  = 1'b1;
              cmd_o.mul_sel = MS_R2;
            end
          end
          OP_CLEAR: begin
            cmd_o.clear    = 1'b1;
            cmd_o.res_load = 1'b1;
          end
          default: begin
            cmd_o.res_load   = 1'b1;
            cmd_o.res_status = ST_MISS;
          end
        endcase
      end
      S_DIR_R3: begin
        if (sts_i.range_ok) begin
          cmd_o.r2_load = 1'b1;
          cmd_o.mul_en  = 1'b1;
          cmd_o.mul_sel = MS_R3;
        end else begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = ST_MISS;
        end
      end
      S_DIR_SP: begin
        cmd_o.mul_en   = 1'b1;
        cmd_o.mul_sel  = MS_SP;
        cmd_o.acc_init = 1'b1;
      end
      S_DIR_DP: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MS_DP;
        cmd_o.acc_add = 1'b1;
      end
      S_DIR_DI: begin
        cmd_o.mul_en  = 1'b1;
        cmd_o.mul_sel = MS_DI;
        cmd_o.acc_add = 1'b1;
      end
      S_DIR_SUM: begin
        cmd_o.res_load = 1'b1;
        cmd_o.res_sel  = RS_ACC;
      end
      S_SEARCH: begin
        cmd_o.search_run = 1'b1;
        if (sts_i.hit) begin
          cmd_o.res_load = 1'b1;
          cmd_o.res_sel  = RS_HIT;
        end else if (sts_i.search_end) begin
          cmd_o.res_load   = 1'b1;
          cmd_o.res_status = ST_MISS;
        end
      end
      S_FINISH: begin
        cmd_o.out_load = sts_i.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

@@ hdl/ftsl_dp.sv @@
module ftsl_dp import ftsl_pkg::*; #(
  parameter int unsigned TableDepth = TABLE_DEPTH_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  ftsl_cfg_t   cfg_i,
  input  ftsl_cmd_t   cmd_i,
  output ftsl_sts_t   sts_o,
  input  logic [95:0] in_data_i,
  input  logic [1:0]  in_user_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] out_data_o,
  output logic [1:0]  out_user_o
);

  localparam int unsigned Aw = $clog2(TableDepth);
  localparam int unsigned Cw = $clog2(TableDepth + 1);

  // latched item
  logic [1:0]  op_q;
  logic [31:0] sip_q, dip_q;
  logic [15:0] sport_q, dport_q;
  logic [31:0] si_q, di_q;
  logic [15:0] sp_q, dp_q;
  logic        range_ok_q;

  // direct index arithmetic
  logic [31:0] prod_q, r2_q, acc_q;
  logic [31:0] mul_a, mul_b, mul_p;

  // table and search
  logic [Cw-1:0] count_q, count_d;
  logic [Cw-1:0] ptr_q;
  logic [Cw-1:0] cmp_idx_q;
  logic          cmp_vld_q;
  logic          issue, hit;
  logic [63:0]   rd_addr;
  logic [31:0]   rd_ports;

  // result and output stage
  logic [1:0]  res_status_q;
  logic [31:0] res_idx_q, res_idx_d;
  logic        out_valid_q;
  logic [1:0]  out_user_q;
  logic [31:0] out_data_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      op_q    <= in_user_i;
      sip_q   <= in_data_i[31:0];
      dip_q   <= in_data_i[63:32];
      sport_q <= in_data_i[79:64];
      dport_q <= in_data_i[95:80];
      si_q    <= in_data_i[31:0] - cfg_i.src_ip_base;
      di_q    <= in_data_i[63:32] - cfg_i.dst_ip_base;
      sp_q    <= in_data_i[79:64] - cfg_i.port_bases[31:16];
      dp_q    <= in_data_i[95:80] - cfg_i.port_bases[15:0];
    end
    range_ok_q <= (si_q < {16'b0, cfg_i.src_ip_count}) &&
                  (di_q < {16'b0, cfg_i.dst_ip_count}) &&
                  (sp_q < cfg_i.src_port_count) &&
                  (dp_q < cfg_i.dst_port_count);
  end

  always_comb begin
    unique case (cmd_i.mul_sel)
      MS_R2: begin
        mul_a = {16'b0, cfg_i.src_ip_count};
        mul_b = {16'b0, cfg_i.dst_ip_count};
      end
      MS_R3: begin
        mul_a = prod_q;
        mul_b = {16'b0, cfg_i.dst_port_count};
      end
      MS_SP: begin
        mul_a = prod_q;
        mul_b = {16'b0, sp_q};
      end
      MS_DP: begin
        mul_a = r2_q;
        mul_b = {16'b0, dp_q};
      end
      MS_DI: begin
        mul_a = di_q;
        mul_b = {16'b0, cfg_i.src_ip_count};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // wraps modulo 2^32
  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) prod_q <= mul_p;
    if (cmd_i.r2_load) r2_q <= prod_q;
    if (cmd_i.acc_init) begin
      acc_q <= si_q;
    end else if (cmd_i.acc_add) begin
      acc_q <= acc_q + prod_q;
    end
  end

  // table fill level
  always_comb begin
    count_d = count_q;
    if (cmd_i.clear) begin
      count_d = '0;
    end else if (cmd_i.append_wr) begin
      count_d = count_q + Cw'(1);
    end
  end

  // linear search: read one entry a cycle, compare it the cycle after
  assign issue = cmd_i.search_run && !hit && (ptr_q < count_q);
  assign hit   = cmp_vld_q && (rd_addr == {sip_q, dip_q}) &&
                 (rd_ports == {sport_q, dport_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      cmp_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q   <= count_d;
      cmp_vld_q <= issue;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.search_start) begin
      ptr_q <= '0;
    end else if (issue) begin
      ptr_q <= ptr_q + Cw'(1);
    end
    if (issue) cmp_idx_q <= ptr_q;
  end

  ftsl_ram #(
    .Width (64),
    .Depth (TableDepth)
  ) u_addr_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.append_wr),
    .waddr_i (count_q[Aw-1:0]),
    .wdata_i ({sip_q, dip_q}),
    .re_i    (issue),
    .raddr_i (ptr_q[Aw-1:0]),
    .rdata_o (rd_addr)
  );

  ftsl_ram #(
    .Width (32),
    .Depth (TableDepth)
  ) u_port_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.append_wr),
    .waddr_i (count_q[Aw-1:0]),
    .wdata_i ({sport_q, dport_q}),
    .re_i    (issue),
    .raddr_i (ptr_q[Aw-1:0]),
    .rdata_o (rd_ports)
  );

  always_comb begin
    unique case (cmd_i.res_sel)
      RS_ZERO:  res_idx_d = '0;
      RS_COUNT: res_idx_d = 32'(count_q);
      RS_ACC:   res_idx_d = acc_q + prod_q;
      RS_HIT:   res_idx_d = 32'(cmp_idx_q);
      default:  res_idx_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.res_load) begin
      res_status_q <= cmd_i.res_status;
      res_idx_q    <= res_idx_d;
    end
    if (cmd_i.out_load) begin
      out_user_q <= res_status_q;
      out_data_q <= res_idx_q;
    end
  end

  assign sts_o.op         = op_q;
  assign sts_o.shuffled   = cfg_i.shuffled;
  assign sts_o.full       = (count_q == Cw'(TableDepth));
  assign sts_o.range_ok   = range_ok_q;
  assign sts_o.hit        = hit;
  assign sts_o.search_end = !issue && !cmp_vld_q;
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;
  assign out_user_o  = out_user_q;

endmodule

@@ tb/sv/session_lookup_checker.sv @@
module session_lookup_checker
  import ftsl_pkg::*;
#(
  parameter int unsigned DEPTH = TABLE_DEPTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  input  logic              s_axis_tready,
  // src_ip[31:0], dst_ip[63:32], src_port[79:64], dst_port[95:80]
  input  logic [95:0]       s_axis_tdata,
  // opcode[1:0]
  input  logic [1:0]        s_axis_tuser,
  input  logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // session_index[31:0]
  input  logic [31:0]       m_axis_tdata,
  // status[1:0]
  input  logic [1:0]        m_axis_tuser,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [31:0]       pwdata,
  input  logic              pready,
  output int unsigned       mismatches_o,
  output int unsigned       outstanding_o
);

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] index;
  } session_t;

  logic        mode;
  logic [31:0] sip_base;
  logic [31:0] dip_base;
  logic [31:0] port_bases;
  logic [15:0] sip_cnt;
  logic [15:0] dip_cnt;
  logic [15:0] sp_cnt;
  logic [15:0] dp_cnt;

  logic [63:0] addr_mem [DEPTH];
  logic [31:0] port_mem [DEPTH];
  int unsigned fill;

  session_t expected_sessions [$];

  function automatic session_t direct_session(input logic [31:0] sip, dip,
                                              input logic [15:0] sp, dp);
    logic [31:0] so, dof, r1, r2, r3;
    logic [15:0] spo, dpo;
    session_t    res;
    so  = sip - sip_base;
    dof = dip - dip_base;
    spo = sp - port_bases[31:16];
    dpo = dp - port_bases[15:0];
    res.status = ST_MISS;
    res.index  = '0;
    if (so < sip_cnt && dof < dip_cnt && spo < sp_cnt && dpo < dp_cnt) begin
      // mixed radix, everything wraps at 32 bits
      r1 = 32'(sip_cnt);
      r2 = r1 * 32'(dip_cnt);
      r3 = r2 * 32'(dp_cnt);
      res.status = ST_OK;
      res.index  = 32'(spo) * r3 + 32'(dpo) * r2 + dof * r1 + so;
    end
    return res;
  endfunction

  function automatic session_t search_session(input logic [63:0] addr,
                                              input logic [31:0] ports);
    session_t res;
    res.status = ST_MISS;
    res.index  = '0;
    // walking downwards leaves the lowest matching position
    for (int i = int'(fill) - 1; i >= 0; i--) begin
      if (addr_mem[i] == addr && port_mem[i] == ports) begin
        res.status = ST_OK;
        res.index  = i;
      end
    end
    return res;
  endfunction

  function automatic session_t resolve_session(input logic [1:0]  op,
                                               input logic [95:0] tup);
    logic [31:0] sip, dip;
    logic [15:0] sp, dp;
    session_t    res;
    sip = tup[31:0];
    dip = tup[63:32];
    sp  = tup[79:64];
    dp  = tup[95:80];
    res.status = ST_MISS;
    res.index  = '0;
    case (op)
      OP_APPEND: begin
        if (fill >= DEPTH) begin
          res.status = ST_FULL;
        end else begin
          addr_mem[fill] = {sip, dip};
          port_mem[fill] = {sp, dp};
          res.status = ST_OK;
          res.index  = fill;
          fill++;
        end
      end
      OP_LOOKUP: begin
        if (mode) res = search_session({sip, dip}, {sp, dp});
        else res = direct_session(sip, dip, sp, dp);
      end
      OP_CLEAR: begin
        fill = 0;
        res.status = ST_OK;
      end
      default: ;
    endcase
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    session_t exp_s;
    logic     bad;
    if (!rst_ni) begin
      mode       = 1'b0;
      sip_base   = '0;
      dip_base   = '0;
      port_bases = '0;
      sip_cnt    = 16'd1;
      dip_cnt    = 16'd1;
      sp_cnt     = 16'd1;
      dp_cnt     = 16'd1;
      fill       = 0;
      expected_sessions.delete();
      mismatches_o  <= 0;
      outstanding_o <= 0;
    end else begin
      bad = 1'b0;
      // result side first so that a transfer in the same cycle is not matched to itself
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_sessions.size() == 0) begin
          $display("%0t: result with nothing expected: got status %0d index %0d",
                   $time, m_axis_tuser, m_axis_tdata);
          bad = 1'b1;
        end else begin
          exp_s = expected_sessions.pop_front();
          if (m_axis_tuser !== exp_s.status) begin
            $display("%0t: status mismatch: expected %0d got %0d",
                     $time, exp_s.status, m_axis_tuser);
            bad = 1'b1;
          end
          if (m_axis_tdata !== exp_s.index) begin
            $display("%0t: session index mismatch: expected %0d got %0d",
                     $time, exp_s.index, m_axis_tdata);
            bad = 1'b1;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_sessions.push_back(resolve_session(s_axis_tuser, s_axis_tdata));
      if (psel && penable && pwrite && pready) begin
        case (paddr[APB_AW-1:2])
          REG_MODE:     mode       = pwdata[0];
          REG_SIP_BASE: sip_base   = pwdata;
          REG_DIP_BASE: dip_base   = pwdata;
          REG_PORTS:    port_bases = pwdata;
          REG_SIP_CNT:  sip_cnt    = pwdata[15:0];
          REG_DIP_CNT:  dip_cnt    = pwdata[15:0];
          REG_SP_CNT:   sp_cnt     = pwdata[15:0];
          REG_DP_CNT:   dp_cnt     = pwdata[15:0];
          default: ;
        endcase
      end
      if (bad) mismatches_o <= mismatches_o + 1;
      outstanding_o <= expected_sessions.size();
    end
  end

endmodule

@@ tb/sv/tb.sv @@
module tb;
  import ftsl_pkg::*;

  localparam logic [1:0]  OP_UNUSED = 2'd3;
  localparam int unsigned DEPTH     = TABLE_DEPTH_DEF;

  typedef struct packed {
    logic [15:0] dp;
    logic [15:0] sp;
    logic [31:0] dip;
    logic [31:0] sip;
  } tuple_t;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [95:0]       s_axis_tdata  = '0;
  logic [1:0]        s_axis_tuser  = OP_APPEND;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [31:0]       m_axis_tdata;
  logic [1:0]        m_axis_tuser;
  logic              psel          = 1'b0;
  logic              penable       = 1'b0;
  logic              pwrite        = 1'b0;
  logic [APB_AW-1:0] paddr         = '0;
  logic [31:0]       pwdata        = '0;
  logic [31:0]       prdata;
  logic              pready;

  int unsigned mismatches;
  int unsigned outstanding;

  int   send_idle_pct = 8;
  int   recv_idle_pct = 77;
  logic stall_kick    = 1'b0;
  logic stall_seen    = 1'b0;
  int   stall_left    = 0;

  // register contents as the stimulus sees them
  logic        shuffled   = 1'b0;
  logic [31:0] sip_base   = '0;
  logic [31:0] dip_base   = '0;
  logic [31:0] port_bases = '0;
  logic [15:0] sip_cnt    = 16'd1;
  logic [15:0] dip_cnt    = 16'd1;
  logic [15:0] sp_cnt     = 16'd1;
  logic [15:0] dp_cnt     = 16'd1;
  tuple_t      loaded [$];

  flow_tuple_session_lookup i_dut (.*);

  session_lookup_checker i_checker (
    .*,
    .mismatches_o (mismatches),
    .outstanding_o(outstanding)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #100_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // receiver: random back-pressure, plus a long hold-off on request
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      stall_left    <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (stall_kick != stall_seen) begin
      stall_seen    <= stall_kick;
      stall_left    <= 300;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic tuple_t tuple_of(input logic [31:0] sip, dip,
                                      input logic [15:0] sp, dp);
    return {dp, sp, dip, sip};
  endfunction

  function automatic tuple_t random_tuple();
    return {$urandom, $urandom, $urandom};
  endfunction

  // tuple inside the configured ranges, or just past the range of one field
  function automatic tuple_t ranged_tuple(input int bad_field);
    int unsigned off [4];
    int unsigned cnt [4];
    tuple_t      t;
    cnt = '{sip_cnt, dip_cnt, sp_cnt, dp_cnt};
    for (int f = 0; f < 4; f++) begin
      if (f == bad_field) begin
        off[f] = cnt[f] + $urandom_range(2);
      end else if (cnt[f] == 0) begin
        off[f] = 0;
      end else begin
        case ($urandom_range(3))
          0:       off[f] = 0;
          1:       off[f] = cnt[f] - 1;
          default: off[f] = $urandom_range(cnt[f] - 1);
        endcase
      end
    end
    t.sip = sip_base + off[0];
    t.dip = dip_base + off[1];
    t.sp  = port_bases[31:16] + off[2][15:0];
    t.dp  = port_bases[15:0] + off[3][15:0];
    return t;
  endfunction

  task automatic send_item(input logic [1:0] op, input tuple_t tup);
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= tup;
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    if (op == OP_APPEND && loaded.size() < DEPTH) loaded.push_back(tup);
    else if (op == OP_CLEAR) loaded.delete();
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_config(input logic mode, input logic [31:0] sb, db, pb,
                            input logic [31:0] c_si, c_di, c_sp, c_dp);
    reg_write(REG_MODE, {31'b0, mode});
    reg_write(REG_SIP_BASE, sb);
    reg_write(REG_DIP_BASE, db);
    reg_write(REG_PORTS, pb);
    reg_write(REG_SIP_CNT, c_si);
    reg_write(REG_DIP_CNT, c_di);
    reg_write(REG_SP_CNT, c_sp);
    reg_write(REG_DP_CNT, c_dp);
    shuffled   = mode;
    sip_base   = sb;
    dip_base   = db;
    port_bases = pb;
    sip_cnt    = c_si[15:0];
    dip_cnt    = c_di[15:0];
    sp_cnt     = c_sp[15:0];
    dp_cnt     = c_dp[15:0];
  endtask

  task automatic direct_item();
    int r;
    r = $urandom_range(99);
    if (r < 72) send_item(OP_LOOKUP, ranged_tuple(-1));
    else if (r < 86) send_item(OP_LOOKUP, ranged_tuple($urandom_range(3)));
    else if (r < 92) send_item(OP_LOOKUP, random_tuple());
    else if (r < 96) send_item(OP_APPEND, random_tuple());
    else if (r < 98) send_item(OP_CLEAR, random_tuple());
    else send_item(OP_UNUSED, random_tuple());
  endtask

  // mostly appends and lookups of loaded tuples, some near misses
  task automatic search_item(input int cap, input int clear_pct);
    int     r;
    tuple_t t;
    r = $urandom_range(99);
    if (r < 35) begin
      if (loaded.size() >= cap) begin
        send_item(OP_CLEAR, random_tuple());
      end else begin
        t = random_tuple();
        if (loaded.size() != 0 && $urandom_range(3) == 0) begin
          t = loaded[$urandom_range(loaded.size() - 1)];
          if ($urandom_range(1) == 0) t = t ^ (96'b1 << $urandom_range(95));
        end
        send_item(OP_APPEND, t);
      end
    end else if (r < 97 - clear_pct) begin
      if (loaded.size() != 0 && $urandom_range(3) != 0) begin
        t = loaded[$urandom_range(loaded.size() - 1)];
        if ($urandom_range(4) == 0) t = t ^ (96'b1 << $urandom_range(95));
      end else begin
        t = random_tuple();
      end
      send_item(OP_LOOKUP, t);
    end else if (r < 97) begin
      send_item(OP_CLEAR, random_tuple());
    end else begin
      send_item(OP_UNUSED, random_tuple());
    end
  endtask

  initial begin
    tuple_t a_tup;
    tuple_t b_tup;
    tuple_t probe;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset ranges hold a single tuple
    send_item(OP_LOOKUP, tuple_of(0, 0, 0, 0));
    send_item(OP_LOOKUP, tuple_of(1, 0, 0, 0));
    send_item(OP_UNUSED, '1);
    send_item(OP_APPEND, '0);
    send_item(OP_APPEND, '1);
    send_item(OP_CLEAR, '0);
    drain();

    // source range wraps past zero, source port base at the top
    set_config(1'b0, 32'hFFFF_FFF0, 32'h0, 32'hFFFF_0000, 32'h20, 32'd3, 32'd2, 32'd5);
    send_item(OP_LOOKUP, tuple_of(32'hFFFF_FFF0, 32'h0, 16'hFFFF, 16'h0));
    send_item(OP_LOOKUP, tuple_of(32'h0000_000F, 32'd2, 16'h0000, 16'd4));
    send_item(OP_LOOKUP, tuple_of(32'h0000_0010, 32'h0, 16'hFFFF, 16'h0));
    send_item(OP_LOOKUP, tuple_of(32'hFFFF_FFF0, 32'h0, 16'hFFFF, 16'd5));
    send_item(OP_LOOKUP, '1);
    drain();

    // full counts, the index overflows 32 bits; upper register bits dropped
    set_config(1'b0, 32'h0, 32'h0, 32'h0, '1, '1, '1, '1);
    send_item(OP_LOOKUP, tuple_of(32'hFFFE, 32'hFFFE, 16'hFFFE, 16'hFFFE));
    send_item(OP_LOOKUP, tuple_of(32'hFFFF, 32'h0, 16'h0, 16'h0));
    drain();

    // an empty range rejects every direct lookup
    set_config(1'b0, 32'h0, 32'h0, 32'h0, '1, '1, 32'h0, '1);
    send_item(OP_LOOKUP, '0);
    drain();

    set_config(1'b1, 32'h0A00_0001, 32'hC0A8_0001, 32'h1234_5678, 32'h0, 32'h0, 32'h0, 32'h0);
    a_tup = random_tuple();
    b_tup = random_tuple();
    send_item(OP_LOOKUP, '0);
    send_item(OP_APPEND, a_tup);
    send_item(OP_APPEND, b_tup);
    send_item(OP_APPEND, a_tup);
    send_item(OP_APPEND, '1);
    send_item(OP_LOOKUP, a_tup);
    send_item(OP_LOOKUP, '1);
    send_item(OP_LOOKUP, a_tup ^ 96'h1);
    send_item(OP_CLEAR, '0);
    send_item(OP_LOOKUP, a_tup);
    send_item(OP_UNUSED, '0);
    drain();

    // load part of the table while the receiver holds off
    stall_kick <= ~stall_kick;
    repeat (150) send_item(OP_APPEND, random_tuple());
    repeat (8) send_item(OP_LOOKUP, loaded[$urandom_range(loaded.size() - 1)]);
    probe = loaded[loaded.size() - 1];
    send_item(OP_LOOKUP, probe);
    send_item(OP_LOOKUP, loaded[0]);
    send_item(OP_LOOKUP, probe ^ 96'h1);
    send_item(OP_CLEAR, '0);
    send_item(OP_LOOKUP, probe);
    drain();

    set_config(1'b0, $urandom, $urandom, $urandom, $urandom_range(1, 8),
               $urandom_range(1, 8), $urandom_range(1, 8), $urandom_range(1, 8));
    repeat (65) direct_item();
    drain();

    set_config(1'b1, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    stall_kick <= ~stall_kick;
    repeat (65) search_item(24, 5);
    drain();

    send_idle_pct <= 77;
    recv_idle_pct <= 8;
    set_config(1'b0, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    repeat (65) direct_item();
    drain();

    set_config(1'b1, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    repeat (65) search_item(64, 2);
    drain();

    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    set_config(1'b0, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, $urandom_range(0, 3),
               $urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 3));
    repeat (65) direct_item();
    drain();

    set_config(1'b1, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
    stall_kick <= ~stall_kick;
    repeat (70) search_item(400, 0);
    drain();

    repeat (50) @(posedge clk_i);
    if (mismatches == 0 && outstanding == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

endmodule
